FILE: rtl/jsu_pkg.sv
// Shared types, character codes and helper functions of the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_END     = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_END    = 3'd1,
    ERR_CTRL   = 3'd2,
    ERR_ESCAPE = 3'd3,
    ERR_HEX    = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESCAPE = 2'd1,
    PH_HEX    = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // one result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    err_t        err;
  } res_t;

  // all results caused by one input item; slot 0 goes out first
  typedef struct packed {
    logic [1:0]      last_idx;
    res_t [3:0]      r;
  } job_t;

  typedef struct packed {
    logic [2:0]       n;
    logic [3:0][7:0]  b;
  } utf8_t;

  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = 2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTRL_MAX  = 8'h1F;

  localparam logic [5:0] SURR_HIGH = 6'b110110;
  localparam logic [5:0] SURR_LOW  = 6'b110111;
  localparam logic [20:0] ASTRAL_BASE = 21'h10000;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.n    = 3'd1;
      e.b[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      e.n    = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.n    = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.n    = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return h;
  endfunction

  // {valid, decoded byte} for the letter after a backslash (not u)
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] m;
    unique case (c)
      8'h62:     m = {1'b1, 8'h08};
      8'h66:     m = {1'b1, 8'h0C};
      8'h6E:     m = {1'b1, 8'h0A};
      8'h72:     m = {1'b1, 8'h0D};
      8'h74:     m = {1'b1, 8'h09};
      CH_QUOTE:  m = {1'b1, CH_QUOTE};
      CH_BSLASH: m = {1'b1, CH_BSLASH};
      CH_SLASH:  m = {1'b1, CH_SLASH};
      default:   m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/jsu_front.sv
// Front end: takes input items, tracks the escape state, builds at most one job per item.
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [1:0]    op,
  input  logic [7:0]    byte_in,
  input  logic          jq_full,
  output logic          jq_push,
  output jsu_pkg::job_t jq_data
);
  import jsu_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [15:0] pending_code, pending_code_next;
  logic        pending_valid, pending_valid_next;

  logic        accept;
  logic        flush, add, astral;
  res_t        add_r;
  logic [4:0]  hd;
  logic [8:0]  em;
  logic [15:0] acc_new;
  logic [20:0] astral_cp;
  utf8_t       pend, ast;
  logic [2:0]  n;

  assign accept    = push && !jq_full;
  assign hd        = hex_digit(byte_in);
  assign em        = esc_map(byte_in);
  assign acc_new   = {hex_accum[11:0], hd[3:0]};
  assign astral_cp = 21'({pending_code[9:0], acc_new[9:0]}) + ASTRAL_BASE;
  assign pend      = utf8_enc({5'd0, pending_code});
  assign ast       = utf8_enc(astral_cp);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_NORMAL;
      hex_count     <= '0;
      hex_accum     <= '0;
      pending_code  <= '0;
      pending_valid <= 1'b0;
    end else begin
      phase         <= phase_next;
      hex_count     <= hex_count_next;
      hex_accum     <= hex_accum_next;
      pending_code  <= pending_code_next;
      pending_valid <= pending_valid_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    hex_count_next     = hex_count;
    hex_accum_next     = hex_accum;
    pending_code_next  = pending_code;
    pending_valid_next = pending_valid;
    flush              = 1'b0;
    add                = 1'b0;
    astral             = 1'b0;
    add_r              = '{kind: KIND_BYTE, data: 8'd0, err: ERR_NONE};

    if (accept) begin
      if (op_t'(op) == OP_RESTART) begin
        phase_next         = PH_NORMAL;
        hex_count_next     = '0;
        hex_accum_next     = '0;
        pending_code_next  = '0;
        pending_valid_next = 1'b0;
      end else if (op_t'(op) == OP_END && phase != PH_DONE) begin
        add                = 1'b1;
        add_r              = '{kind: KIND_ERROR, data: 8'd0,
                               err: (phase == PH_HEX) ? ERR_HEX : ERR_END};
        phase_next         = PH_DONE;
        pending_code_next  = '0;
        pending_valid_next = 1'b0;
      end else if (op_t'(op) == OP_DATA) begin
        unique case (phase)
          PH_NORMAL: begin
            if (byte_in == CH_QUOTE) begin
              flush      = 1'b1;
              add        = 1'b1;
              add_r      = '{kind: KIND_CLOSED, data: 8'd0, err: ERR_NONE};
              phase_next = PH_DONE;
            end else if (byte_in <= CTRL_MAX) begin
              add                = 1'b1;
              add_r              = '{kind: KIND_ERROR, data: 8'd0, err: ERR_CTRL};
              phase_next         = PH_DONE;
              pending_code_next  = '0;
              pending_valid_next = 1'b0;
            end else if (byte_in == CH_BSLASH) begin
              phase_next = PH_ESCAPE;
            end else begin
              flush = 1'b1;
              add   = 1'b1;
              add_r = '{kind: KIND_BYTE, data: byte_in, err: ERR_NONE};
            end
          end
          PH_ESCAPE: begin
            if (byte_in == CH_U) begin
              phase_next     = PH_HEX;
              hex_count_next = '0;
              hex_accum_next = '0;
            end else if (!em[8]) begin
              add                = 1'b1;
              add_r              = '{kind: KIND_ERROR, data: 8'd0, err: ERR_ESCAPE};
              phase_next         = PH_DONE;
              pending_code_next  = '0;
              pending_valid_next = 1'b0;
            end else begin
              flush      = 1'b1;
              add        = 1'b1;
              add_r      = '{kind: KIND_BYTE, data: em[7:0], err: ERR_NONE};
              phase_next = PH_NORMAL;
            end
          end
          PH_HEX: begin
            if (!hd[4]) begin
              add                = 1'b1;
              add_r              = '{kind: KIND_ERROR, data: 8'd0, err: ERR_HEX};
              phase_next         = PH_DONE;
              pending_code_next  = '0;
              pending_valid_next = 1'b0;
            end else if (hex_count != 2'd3) begin
              hex_count_next = hex_count + 2'd1;
              hex_accum_next = acc_new;
            end else begin
              if (pending_valid && pending_code[15:10] == SURR_HIGH &&
                  acc_new[15:10] == SURR_LOW) begin
                astral             = 1'b1;
                pending_code_next  = '0;
                pending_valid_next = 1'b0;
              end else begin
                flush              = 1'b1;
                pending_code_next  = acc_new;
                pending_valid_next = 1'b1;
              end
              hex_count_next = '0;
              hex_accum_next = '0;
              phase_next     = PH_NORMAL;
            end
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
    end

    // flushing a held code point clears it unless a new one replaces it
    if (flush && !(phase == PH_HEX)) begin
      pending_code_next  = '0;
      pending_valid_next = 1'b0;
    end

    // job assembly
    jq_data = '0;
    n       = '0;
    if (astral) begin
      for (int i = 0; i < 4; i++) begin
        jq_data.r[i] = '{kind: KIND_BYTE, data: ast.b[i], err: ERR_NONE};
      end
      n = 3'd4;
    end else begin
      if (flush && pending_valid) begin
        for (int i = 0; i < 4; i++) begin
          jq_data.r[i] = '{kind: KIND_BYTE, data: pend.b[i], err: ERR_NONE};
        end
        n = pend.n;
      end
      if (add) begin
        jq_data.r[n[1:0]] = add_r;
        n = n + 3'd1;
      end
    end
    jq_data.last_idx = 2'(n - 3'd1);
    jq_push          = accept && (n != 3'd0);
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    accept && op_t'(op) == OP_RESTART |=> phase == PH_NORMAL && !pending_valid)
    else $error("restart left state behind");

  a_no_pending_when_done: assert property (@(posedge clk) disable iff (rst)
    pending_valid |-> phase != PH_DONE)
    else $error("code point held after string finished");

endmodule

FILE: rtl/jsu_job_fifo.sv
// Short queue of jobs between the front end and the result sequencer.
module jsu_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::job_t wdata,
  input  logic          pop,
  output jsu_pkg::job_t rdata,
  output logic          full,
  output logic          empty
);
  import jsu_pkg::*;

  job_t              mem [JQ_DEPTH];
  logic [JQ_AW-1:0]  wr_ptr, rd_ptr;
  logic [JQ_AW:0]    cnt;

  assign full  = (cnt == (JQ_AW+1)'(JQ_DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("job queue underflow");

endmodule

FILE: rtl/jsu_back.sv
// Back end: unpacks queued jobs into single result items, one per cycle while pop is high.
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  jsu_pkg::job_t jq_data,
  input  logic          jq_empty,
  output logic          jq_pop,
  input  logic          pop,
  output logic          empty,
  output logic [1:0]    kind,
  output logic [7:0]    byte_out,
  output logic [2:0]    error_code,
  output logic          last
);
  import jsu_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       done_item;

  assign empty      = !cur_valid;
  assign kind       = cur.r[idx].kind;
  assign byte_out   = cur.r[idx].data;
  assign error_code = cur.r[idx].err;
  assign last       = (idx == cur.last_idx);
  assign done_item  = cur_valid && pop && last;
  assign jq_pop     = (!cur_valid || done_item) && !jq_empty;

  always_ff @(posedge clk) begin
    if (jq_pop) begin
      cur <= jq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (jq_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (done_item) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (cur_valid && pop) begin
      idx <= idx + 2'd1;
    end
  end

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !cur_valid |-> idx == 2'd0)
    else $error("slot index not parked while idle");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    cur_valid && !pop |=> cur_valid && $stable(idx))
    else $error("result moved without pop");

endmodule

FILE: rtl/json_string_unescape_utf8.sv
// Top level of the JSON string body unescaper with UTF-8 output.
//
//  channel   ports                              handshake
//  --------  ---------------------------------  ----------------------------
//  input     op[1:0], byte_in[7:0]              push & !full
//  result    kind[1:0], byte_out[7:0],          pop & !empty
//            error_code[2:0], last
//
// One input item per cycle enters the front end while full is low; each item makes zero to four
// result items, packed into one job for a four-deep job queue.
// The result sequencer hands out one result item per cycle while pop is high, so the
// sustained input rate is one item per cycle until multibyte output backs the queue up.
// An item's first result passes through the job queue and the back end's job
// register before it reaches the result ports, where pop & !empty takes it.
// full is the job queue's full flag; it rises when results go untaken or when
// multibyte items arrive faster than one result item per cycle drains them.
// rst (synchronous) returns the parser to the plain string body state, drops
// any held code point and empties the queue.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] op,
  input  logic [7:0] byte_in,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [7:0] byte_out,
  output logic [2:0] error_code,
  output logic       last
);
  import jsu_pkg::*;

  job_t jq_wdata, jq_rdata;
  logic jq_push, jq_pop, jq_full, jq_empty;

  assign full = jq_full;

  // escape tracking, surrogate joining and UTF-8 packing
  jsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .op      (op),
    .byte_in (byte_in),
    .jq_full (jq_full),
    .jq_push (jq_push),
    .jq_data (jq_wdata)
  );

  // decouples the front end from output stalls
  jsu_job_fifo u_jq (
    .clk   (clk),
    .rst   (rst),
    .push  (jq_push),
    .wdata (jq_wdata),
    .pop   (jq_pop),
    .rdata (jq_rdata),
    .full  (jq_full),
    .empty (jq_empty)
  );

  // serializes each job into result items, last set on the final one
  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .jq_data    (jq_rdata),
    .jq_empty   (jq_empty),
    .jq_pop     (jq_pop),
    .pop        (pop),
    .empty      (empty),
    .kind       (kind),
    .byte_out   (byte_out),
    .error_code (error_code),
    .last       (last)
  );

endmodule
